@@ src/assert_macros.svh @@
// shared assertion macros, clocked on clock and disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/i2crt_pkg.sv @@
// ----------------------------------------------------------------------------
// i2crt_pkg
// Types and codes shared by the i2c register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crt_pkg;

   localparam int COUNT_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 5;
   localparam int DEV_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // request kinds
   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_LOAD   = 2'd1,
      REQ_EVENT  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   // bus commands
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_DATA      = 3'd1,
      CMD_READ_ADDR = 3'd2,
      CMD_STOP      = 3'd3,
      CMD_ACK_NEXT  = 3'd4,
      CMD_NACK_STOP = 3'd5
   } cmd_type;

   // transfer phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_REGISTER = 4'd1,
      PH_ADDRESS  = 4'd2,
      PH_WRITE    = 4'd3,
      PH_READ     = 4'd4,
      PH_SENT     = 4'd5,
      PH_RECEIVED = 4'd6,
      PH_ERROR    = 4'd7,
      PH_OVERFLOW = 4'd8
   } phase_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEVICE_ADDRESS   = 2'd0,
      CSR_REGISTER_ADDRESS = 2'd1,
      CSR_WRITE_COUNT      = 2'd2,
      CSR_READ_COUNT       = 2'd3
   } csr_index_type;

   // one result as it moves down the pipeline
   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  bus_byte;
      logic               use_store;
      logic               rx_valid;
      logic [INDEX_W-1:0] rx_index;
      phase_type          phase;
      logic               tx_done;
      logic               rx_done;
      logic               error_irq;
   } result_type;

endpackage

@@ src/i2crt_ram.sv @@
// ----------------------------------------------------------------------------
// i2crt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module i2crt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/i2c_master_register_transaction.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_transaction
// Sequencer for one i2c master register read or write transaction.
// ----------------------------------------------------------------------------
// Usage: a start request arms a transaction, load requests fill the write
// buffer, and each bus event request returns the next bus command. Every
// request gives exactly one response on the rsp_ channel. The csr_ port sets
// device address, register address and byte counts; the user writes it only
// while no request is in flight, and the block does not enforce this.
// Pipeline: a request passes the decode register, then the output register.
// The accepting edge registers the decoded request, updates phase and
// positions and reads the write buffer RAM; the edge on which the decode
// stage advances picks the RAM byte into the output register.
// Throughput: one request per cycle while rsp_stall stays low, bounded by
// the single RAM read port, which serves one buffer read per request.
// Reset: phase goes to idle, positions and registers clear, pipeline empties.
// The write buffer keeps no reset value and must be loaded before use.
// Stall: with rsp_stall high the output register holds its response, the
// decode stage still fills once, and then req_stall rises until the output
// drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_register_transaction
   import i2crt_pkg::*;
#(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration port
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [INDEX_W-1:0]    req_byte_index,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  req_arb_lost,
   input  logic                  req_write_flag,
   input  logic                  req_read_flag,
   input  logic                  req_rx_nack,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_bus_command,
   output logic [BYTE_W-1:0]     rsp_bus_byte,
   output logic                  rsp_rx_valid,
   output logic [INDEX_W-1:0]    rsp_rx_index,
   output logic [3:0]            rsp_phase,
   output logic                  rsp_tx_done,
   output logic                  rsp_rx_done,
   output logic                  rsp_error_irq
);

   localparam int ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int DEPTH_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W   = (DEPTH_W > COUNT_W + 1) ? DEPTH_W : COUNT_W + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUFFER_DEPTH);

   // configuration registers
   logic [DEV_W-1:0]   device_address_ff;
   logic [BYTE_W-1:0]  register_address_ff;
   logic [COUNT_W-1:0] write_count_ff;
   logic [COUNT_W-1:0] read_count_ff;

   // transfer state
   phase_type          phase_ff,     phase_in;
   logic [COUNT_W-1:0] write_pos_ff, write_pos_in;
   logic [COUNT_W-1:0] read_pos_ff,  read_pos_in;

   // pipeline
   logic       s1_valid_ff,  s1_valid_in;
   result_type s1_ff,        s1_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff,       out_in;
   logic       s1_adv;
   logic       req_fire;

   // write buffer ports
   logic              store_wr_en;
   logic [ADDR_W-1:0] store_wr_addr;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [BYTE_W-1:0] store_rd_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff   <= '0;
         register_address_ff <= '0;
         write_count_ff      <= '0;
         read_count_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS:   device_address_ff   <= csr_data[DEV_W-1:0];
            CSR_REGISTER_ADDRESS: register_address_ff <= csr_data[BYTE_W-1:0];
            CSR_WRITE_COUNT:      write_count_ff      <= csr_data[COUNT_W-1:0];
            CSR_READ_COUNT:       read_count_ff       <= csr_data[COUNT_W-1:0];
            default:              ;
         endcase
      end
   end

   // handshake: decode stage moves on when the output register is free
   assign s1_adv    = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_fire  = req_valid && !req_stall;

   // request decode and state update
   always_comb begin
      logic [CMP_W-1:0] wr_limit;
      logic [CMP_W-1:0] wpos_ext;
      logic [CMP_W-1:0] rpos_ext;
      logic [CMP_W-1:0] idx_ext;
      logic [CMP_W-1:0] rpos_inc;

      wpos_ext = CMP_W'(write_pos_ff);
      rpos_ext = CMP_W'(read_pos_ff);
      idx_ext  = CMP_W'(req_byte_index);
      rpos_inc = rpos_ext + CMP_W'(1);
      wr_limit = (CMP_W'(write_count_ff) < DEPTH_C) ? CMP_W'(write_count_ff) : DEPTH_C;

      phase_in     = phase_ff;
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;

      s1_in           = '0;
      s1_in.cmd       = CMD_NONE;
      store_wr_en     = 1'b0;
      store_wr_addr   = idx_ext[ADDR_W-1:0];
      store_rd_addr   = wpos_ext[ADDR_W-1:0];

      unique case (req_kind_type'(req_type))
         REQ_START: begin
            phase_in     = PH_REGISTER;
            write_pos_in = '0;
            read_pos_in  = '0;
         end
         REQ_LOAD: begin
            store_wr_en = req_fire && (idx_ext < DEPTH_C);
         end
         REQ_EVENT: begin
            if (req_arb_lost) begin
               phase_in        = PH_ERROR;
               s1_in.cmd       = CMD_STOP;
               s1_in.error_irq = 1'b1;
            end else if (req_write_flag) begin
               if (req_rx_nack) begin
                  phase_in        = PH_ERROR;
                  s1_in.cmd       = CMD_STOP;
                  s1_in.error_irq = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_REGISTER: begin
                        s1_in.cmd      = CMD_DATA;
                        s1_in.bus_byte = register_address_ff;
                        phase_in       = (read_count_ff != '0) ? PH_ADDRESS : PH_WRITE;
                     end
                     PH_ADDRESS: begin
                        s1_in.cmd      = CMD_READ_ADDR;
                        s1_in.bus_byte = {device_address_ff, 1'b1};
                        phase_in       = PH_READ;
                     end
                     PH_WRITE: begin
                        if (wpos_ext < wr_limit) begin
                           s1_in.cmd       = CMD_DATA;
                           s1_in.use_store = 1'b1;
                           write_pos_in    = write_pos_ff + COUNT_W'(1);
                        end else begin
                           s1_in.cmd     = CMD_STOP;
                           s1_in.tx_done = 1'b1;
                           phase_in      = PH_SENT;
                        end
                     end
                     default: ;
                  endcase
               end
            end else if (req_read_flag) begin
               if (phase_ff != PH_READ) begin
                  phase_in        = PH_ERROR;
                  s1_in.cmd       = CMD_STOP;
                  s1_in.error_irq = 1'b1;
               end else if (rpos_ext >= DEPTH_C) begin
                  // buffer full: drop the byte and end the transfer
                  s1_in.cmd = CMD_NACK_STOP;
                  phase_in  = PH_OVERFLOW;
               end else begin
                  s1_in.bus_byte = req_byte_value;
                  s1_in.rx_valid = 1'b1;
                  s1_in.rx_index = read_pos_ff[INDEX_W-1:0];
                  read_pos_in    = rpos_inc[COUNT_W-1:0];
                  if (rpos_inc < CMP_W'(read_count_ff)) begin
                     s1_in.cmd = CMD_ACK_NEXT;
                  end else begin
                     s1_in.cmd     = CMD_NACK_STOP;
                     s1_in.rx_done = 1'b1;
                     phase_in      = PH_RECEIVED;
                  end
               end
            end else begin
               // event with no flag set
               phase_in        = PH_ERROR;
               s1_in.cmd       = CMD_STOP;
               s1_in.error_irq = 1'b1;
            end
         end
         default: ;
      endcase

      s1_in.phase = phase_in;
   end

   // write buffer; a load and a used buffer read never share an edge, so the
   // registered read always sees every earlier load
   i2crt_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (req_byte_value),
      .rd_en   (req_fire),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // pipeline next values
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_in           = s1_ff;
            out_in.use_store = 1'b0;
            if (s1_ff.use_store) begin
               out_in.bus_byte = store_rd_data;
            end
         end
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            write_pos_ff <= write_pos_in;
            read_pos_ff  <= read_pos_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      out_ff <= out_in;
   end

   // response ports
   assign rsp_valid       = out_valid_ff;
   assign rsp_bus_command = out_ff.cmd;
   assign rsp_bus_byte    = out_ff.bus_byte;
   assign rsp_rx_valid    = out_ff.rx_valid;
   assign rsp_rx_index    = out_ff.rx_index;
   assign rsp_phase       = out_ff.phase;
   assign rsp_tx_done     = out_ff.tx_done;
   assign rsp_rx_done     = out_ff.rx_done;
   assign rsp_error_irq   = out_ff.error_irq;

   // checks
   `ASSERT_IMPLIES(a_rx_phase, rsp_valid && rsp_rx_valid,
                   rsp_phase == PH_READ || rsp_phase == PH_RECEIVED,
                   "received byte outside read phase")
   `ASSERT_IMPLIES(a_error_stop, rsp_valid && rsp_error_irq,
                   rsp_bus_command == CMD_STOP && rsp_phase == PH_ERROR,
                   "error without stop")
   `ASSERT_IMPLIES(a_tx_done, rsp_valid && rsp_tx_done,
                   rsp_bus_command == CMD_STOP && rsp_phase == PH_SENT,
                   "write done without stop")
   `ASSERT_IMPLIES(a_store_use, s1_valid_ff && s1_ff.use_store,
                   s1_ff.cmd == CMD_DATA && s1_ff.phase == PH_WRITE,
                   "buffer read outside write phase")
   `ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_adv, s1_valid_ff,
                "decode stage lost a request")

endmodule

@@ verif/tb_i2c_master_register_transaction.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_register_transaction
// Self-checking bench for the i2c register transaction sequencer. A short
// table of directed requests runs first. Random write and read transactions
// follow under several register settings. Both channels get random gaps and
// stalls, and two long response holds back up the request side. Every
// response is checked field by field against the directed table's result or
// a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_transaction;
   import i2crt_pkg::*;

   localparam int STORE_DEPTH       = 32;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int ITEMS_PER_SETTING = 186;
   localparam int NUM_SETTINGS      = 7;
   localparam int NUM_PRESETS       = 5;
   localparam int HOLD_CYCLES       = 80;

   // one request as the bench sees it
   typedef struct packed {
      req_kind_type       kind;
      logic [INDEX_W-1:0] slot;
      logic [BYTE_W-1:0]  value;
      logic               arb_lost;
      logic               write_flag;
      logic               read_flag;
      logic               rx_nack;
   } request_type;

   // one response as the bench predicts it
   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  bus_byte;
      logic               rx_valid;
      logic [INDEX_W-1:0] rx_index;
      phase_type          phase;
      logic               tx_done;
      logic               rx_done;
      logic               error_irq;
   } outcome_type;

   // one line of the directed table: a register write or a request
   typedef struct {
      bit                is_cfg;
      csr_index_type     cfg_index;
      logic [7:0]        cfg_value;
      request_type       rq;
      bit                typed;
      outcome_type       want;
   } dir_row_type;

   localparam outcome_type ERR_RESULT =
      '{CMD_STOP, 8'h00, 1'b0, 5'd0, PH_ERROR, 1'b0, 1'b0, 1'b1};
   localparam outcome_type QUIET_ERROR =
      '{CMD_NONE, 8'h00, 1'b0, 5'd0, PH_ERROR, 1'b0, 1'b0, 1'b0};
   localparam request_type START_REQ =
      '{REQ_START, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_type;
   logic [INDEX_W-1:0]    req_byte_index;
   logic [BYTE_W-1:0]     req_byte_value;
   logic                  req_arb_lost;
   logic                  req_write_flag;
   logic                  req_read_flag;
   logic                  req_rx_nack;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_bus_command;
   logic [BYTE_W-1:0]     rsp_bus_byte;
   logic                  rsp_rx_valid;
   logic [INDEX_W-1:0]    rsp_rx_index;
   logic [3:0]            rsp_phase;
   logic                  rsp_tx_done;
   logic                  rsp_rx_done;
   logic                  rsp_error_irq;

   // sequencer model state and its copy of the registers
   phase_type         model_phase = PH_IDLE;
   logic [5:0]        write_pos = '0;
   logic [5:0]        read_pos = '0;
   logic [7:0]        buffer_bytes [STORE_DEPTH];
   bit [STORE_DEPTH-1:0] slot_loaded = '0;
   logic [6:0]        dev_addr_cfg = '0;
   logic [7:0]        reg_addr_cfg = '0;
   logic [5:0]        write_count_cfg = '0;
   logic [5:0]        read_count_cfg = '0;

   outcome_type pending_results [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 34;
   int          rsp_idle_pct = 56;
   bit          long_hold_due = 1'b0;
   bit          clean_flow = 1'b1;
   dir_row_type plan [$];

   // register presets: write max, read max, oversize write, overflow read, zero counts
   logic [7:0] preset_dev [NUM_PRESETS] = '{8'h7f, 8'h00, 8'h2a, 8'h55, 8'h00};
   logic [7:0] preset_reg [NUM_PRESETS] = '{8'hff, 8'h00, 8'h5a, 8'ha5, 8'hff};
   logic [7:0] preset_wc  [NUM_PRESETS] = '{8'd32, 8'd0, 8'd63, 8'd0, 8'd0};
   logic [7:0] preset_rc  [NUM_PRESETS] = '{8'd0, 8'd32, 8'd0, 8'd63, 8'd0};

   i2c_master_register_transaction u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // data bytes the write flow sends, capped at the buffer size
   function automatic logic [5:0] data_limit();
      return (write_count_cfg < STORE_DEPTH) ? write_count_cfg : 6'(STORE_DEPTH);
   endfunction

   // advance the sequencer model by one request and return its response
   function automatic outcome_type sequencer_step(request_type rq);
      outcome_type res;
      res = '0;
      case (rq.kind)
         REQ_START: begin
            model_phase = PH_REGISTER;
            write_pos = '0;
            read_pos = '0;
         end
         REQ_LOAD: begin
            buffer_bytes[rq.slot] = rq.value;
            slot_loaded[rq.slot] = 1'b1;
         end
         REQ_EVENT: begin
            // arbitration first, then write, then read; no flag is an error
            if (rq.arb_lost || (rq.write_flag && rq.rx_nack) ||
                (!rq.write_flag && !rq.read_flag) ||
                (!rq.write_flag && model_phase != PH_READ)) begin
               model_phase = PH_ERROR;
               res.cmd = CMD_STOP;
               res.error_irq = 1'b1;
            end else if (rq.write_flag) begin
               case (model_phase)
                  PH_REGISTER: begin
                     res.cmd = CMD_DATA;
                     res.bus_byte = reg_addr_cfg;
                     model_phase = (read_count_cfg != 0) ? PH_ADDRESS : PH_WRITE;
                  end
                  PH_ADDRESS: begin
                     res.cmd = CMD_READ_ADDR;
                     res.bus_byte = {dev_addr_cfg, 1'b1};
                     model_phase = PH_READ;
                  end
                  PH_WRITE: begin
                     if (write_pos < data_limit()) begin
                        res.cmd = CMD_DATA;
                        res.bus_byte = buffer_bytes[write_pos[4:0]];
                        write_pos = write_pos + 1'b1;
                     end else begin
                        res.cmd = CMD_STOP;
                        res.tx_done = 1'b1;
                        model_phase = PH_SENT;
                     end
                  end
                  default: ;
               endcase
            end else if (read_pos >= STORE_DEPTH) begin
               // buffer full: drop the byte and end the transfer
               res.cmd = CMD_NACK_STOP;
               model_phase = PH_OVERFLOW;
            end else begin
               res.bus_byte = rq.value;
               res.rx_valid = 1'b1;
               res.rx_index = read_pos[4:0];
               read_pos = read_pos + 1'b1;
               if (read_pos < read_count_cfg) begin
                  res.cmd = CMD_ACK_NEXT;
               end else begin
                  res.cmd = CMD_NACK_STOP;
                  res.rx_done = 1'b1;
                  model_phase = PH_RECEIVED;
               end
            end
         end
         default: ;
      endcase
      res.phase = model_phase;
      return res;
   endfunction

   function automatic request_type bus_event(logic arb, logic wr, logic rd, logic nack,
                                             logic [7:0] val);
      return '{REQ_EVENT, 5'd0, val, arb, wr, rd, nack};
   endfunction

   function automatic request_type load_slot(logic [4:0] slot, logic [7:0] val);
      return '{REQ_LOAD, slot, val, 1'b0, 1'b0, 1'b0, 1'b0};
   endfunction

   function automatic dir_row_type req_row(request_type rq, bit typed, outcome_type want);
      dir_row_type row;
      row.is_cfg = 1'b0;
      row.cfg_index = CSR_DEVICE_ADDRESS;
      row.cfg_value = '0;
      row.rq = rq;
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic dir_row_type cfg_row(csr_index_type idx, logic [7:0] val);
      dir_row_type row;
      row = req_row(START_REQ, 1'b0, '0);
      row.is_cfg = 1'b1;
      row.cfg_index = idx;
      row.cfg_value = val;
      return row;
   endfunction

   // predict, then offer the request until it is taken
   task automatic issue(input request_type rq, input bit typed,
                        input outcome_type typed_out);
      outcome_type predicted;
      predicted = sequencer_step(rq);
      pending_results.push_back(typed ? typed_out : predicted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= rq.kind;
      req_byte_index <= rq.slot;
      req_byte_value <= rq.value;
      req_arb_lost   <= rq.arb_lost;
      req_write_flag <= rq.write_flag;
      req_read_flag  <= rq.read_flag;
      req_rx_nack    <= rq.rx_nack;
      @(negedge clock);
      while (req_stall) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // drain every outstanding response, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] val);
      case (idx)
         CSR_DEVICE_ADDRESS:   dev_addr_cfg = val[6:0];
         CSR_REGISTER_ADDRESS: reg_addr_cfg = val;
         CSR_WRITE_COUNT:      write_count_cfg = val[5:0];
         default:              read_count_cfg = val[5:0];
      endcase
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // response checker, sampled mid-cycle
   always @(negedge clock) begin : response_check
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual cmd %0d",
                     $time, rsp_bus_command);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("bus_command", want.cmd, rsp_bus_command);
            check_field("bus_byte", want.bus_byte, rsp_bus_byte);
            check_field("rx_valid", want.rx_valid, rsp_rx_valid);
            check_field("rx_index", want.rx_index, rsp_rx_index);
            check_field("phase", want.phase, rsp_phase);
            check_field("tx_done", want.tx_done, rsp_tx_done);
            check_field("rx_done", want.rx_done, rsp_rx_done);
            check_field("error_irq", want.error_irq, rsp_error_irq);
         end
      end
   end

   // response side stalls, with one long hold on request
   initial begin : response_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // run limit
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_i2c_master_register_transaction: errors");
      $finish;
   end

   // stimulus
   initial begin : request_side
      request_type rq;
      int          random_count;
      int          setting_items;

      reset          <= 1'b1;
      csr_write      <= 1'b0;
      csr_index      <= CSR_DEVICE_ADDRESS;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_type       <= REQ_START;
      req_byte_index <= '0;
      req_byte_value <= '0;
      req_arb_lost   <= 1'b0;
      req_write_flag <= 1'b0;
      req_read_flag  <= 1'b0;
      req_rx_nack    <= 1'b0;
      random_count = 0;

      // directed table: errors after reset, a write flow, a read flow, an arbitration loss
      plan.push_back(req_row(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1, ERR_RESULT));
      plan.push_back(req_row('{REQ_UNUSED, 5'd31, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
                             QUIET_ERROR));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1, QUIET_ERROR));
      plan.push_back(req_row(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h3c), 1'b1, ERR_RESULT));
      plan.push_back(req_row(load_slot(5'd0, 8'hff), 1'b1, QUIET_ERROR));
      plan.push_back(req_row(load_slot(5'd31, 8'h00), 1'b1, QUIET_ERROR));
      plan.push_back(req_row(load_slot(5'd1, 8'h5a), 1'b0, '0));
      plan.push_back(cfg_row(CSR_DEVICE_ADDRESS, 8'h7f));
      plan.push_back(cfg_row(CSR_REGISTER_ADDRESS, 8'hff));
      plan.push_back(cfg_row(CSR_WRITE_COUNT, 8'd2));
      plan.push_back(cfg_row(CSR_READ_COUNT, 8'd0));
      plan.push_back(req_row(START_REQ, 1'b1,
                             '{CMD_NONE, 8'h00, 1'b0, 5'd0, PH_REGISTER, 1'b0, 1'b0, 1'b0}));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1,
                             '{CMD_DATA, 8'hff, 1'b0, 5'd0, PH_WRITE, 1'b0, 1'b0, 1'b0}));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1,
                             '{CMD_STOP, 8'h00, 1'b0, 5'd0, PH_SENT, 1'b1, 1'b0, 1'b0}));
      // write outranks read, and is ignored once sent
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b1, 1'b0, 8'h80), 1'b0, '0));
      plan.push_back(req_row(START_REQ, 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h00), 1'b1, ERR_RESULT));
      plan.push_back(cfg_row(CSR_READ_COUNT, 8'd1));
      plan.push_back(req_row(START_REQ, 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1,
                             '{CMD_READ_ADDR, 8'hff, 1'b0, 5'd0, PH_READ, 1'b0, 1'b0, 1'b0}));
      plan.push_back(req_row(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 8'hff), 1'b1,
                             '{CMD_NACK_STOP, 8'hff, 1'b1, 5'd0, PH_RECEIVED,
                               1'b0, 1'b1, 1'b0}));
      plan.push_back(req_row(bus_event(1'b0, 1'b0, 1'b1, 1'b1, 8'h01), 1'b1, ERR_RESULT));
      plan.push_back(req_row(START_REQ, 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0));
      plan.push_back(req_row(bus_event(1'b1, 1'b1, 1'b1, 1'b1, 8'h7e), 1'b1, ERR_RESULT));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            wait_idle();
            write_register(plan[i].cfg_index, plan[i].cfg_value);
         end else begin
            issue(plan[i].rq, plan[i].typed, plan[i].want);
         end
      end

      // random transactions under each register setting
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_idle();
         if (s < NUM_PRESETS) begin
            write_register(CSR_DEVICE_ADDRESS, preset_dev[s]);
            write_register(CSR_REGISTER_ADDRESS, preset_reg[s]);
            write_register(CSR_WRITE_COUNT, preset_wc[s]);
            write_register(CSR_READ_COUNT, preset_rc[s]);
         end else begin
            write_register(CSR_DEVICE_ADDRESS, 8'($urandom_range(127)));
            write_register(CSR_REGISTER_ADDRESS, 8'($urandom_range(255)));
            write_register(CSR_WRITE_COUNT, 8'($urandom_range(6)));
            write_register(CSR_READ_COUNT,
                           $urandom_range(1) ? 8'($urandom_range(6, 1)) : 8'd0);
         end

         setting_items = 0;
         while (setting_items < ITEMS_PER_SETTING) begin
            // idling: receiver-heavy, then sender-heavy, then none
            if (random_count < 433) begin
               send_idle_pct = 34;
               rsp_idle_pct = 56;
            end else if (random_count < 866) begin
               send_idle_pct = 56;
               rsp_idle_pct = 34;
            end else begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end

            rq.kind       = req_kind_type'($urandom_range(3));
            rq.slot       = 5'($urandom);
            rq.value      = 8'($urandom);
            rq.arb_lost   = 1'($urandom_range(1));
            rq.write_flag = 1'($urandom_range(1));
            rq.read_flag  = 1'($urandom_range(1));
            rq.rx_nack    = 1'($urandom_range(1));

            // noisy transactions keep some fully random requests
            if (clean_flow || $urandom_range(99) >= 15) begin
               if ($urandom_range(99) < 10) begin
                  rq.kind = REQ_LOAD;
               end else begin
                  case (model_phase)
                     PH_REGISTER, PH_ADDRESS, PH_WRITE: begin
                        rq.kind = REQ_EVENT;
                        rq.arb_lost = 1'b0;
                        rq.write_flag = 1'b1;
                        rq.rx_nack = 1'b0;
                     end
                     PH_READ: begin
                        rq.kind = REQ_EVENT;
                        rq.arb_lost = 1'b0;
                        rq.write_flag = 1'b0;
                        rq.read_flag = 1'b1;
                     end
                     default: begin
                        rq.kind = REQ_START;
                        clean_flow = ($urandom_range(99) < 70);
                     end
                  endcase
               end
            end

            // never send a buffer slot that holds no loaded byte
            if (rq.kind == REQ_EVENT && !rq.arb_lost && rq.write_flag && !rq.rx_nack &&
                model_phase == PH_WRITE && write_pos < data_limit() &&
                !slot_loaded[write_pos[4:0]])
               issue(load_slot(write_pos[4:0], 8'($urandom)), 1'b0, '0);

            issue(rq, 1'b0, '0);
            if (rq.kind != REQ_UNUSED) begin
               setting_items++;
               random_count++;
               if (random_count == 100 || random_count == 1100) long_hold_due = 1'b1;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb_i2c_master_register_transaction: clean");
      end else begin
         $display("tb_i2c_master_register_transaction: errors");
      end
      $finish;
   end

endmodule
